FILE: design/grbf_pkg.sv
`default_nettype none
package grbf_pkg;

    localparam int NUM_BASIS_DEF = 64;
    localparam int DIMS_DEF      = 8;

    localparam int FUNC_W   = 2;
    localparam int BIDX_W   = 6;
    localparam int DIDX_W   = 3;
    localparam int COORD_W  = 24;
    localparam int WEIGHT_W = 32;
    localparam int INV_W    = 24;
    localparam int DIST_W   = 48;
    localparam int RATIO_W  = 32;
    localparam int APB_AW   = 2;
    localparam int APB_DW   = 32;

    localparam logic [INV_W-1:0]  INV_RESET    = 24'd65536;
    localparam logic [APB_AW-1:0] REG_INV_ADDR = 2'd0;

    localparam int          SERIES_TERMS = 14;
    localparam logic [30:0] EXP_NEG1_Q32 = 31'd1580030169;

    typedef enum logic [1:0] {
        FUNC_CENTER = 2'd0,
        FUNC_WEIGHT = 2'd1,
        FUNC_SAMPLE = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        OP_CENTER = 2'd0,
        OP_WEIGHT = 2'd1,
        OP_SAMPLE = 2'd2
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic [BIDX_W-1:0]          bidx;
        logic [DIDX_W-1:0]          didx;
        logic signed [COORD_W-1:0]  coord;
        logic [WEIGHT_W-1:0]        weight;
        logic                       acc_en;
        logic                       last;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_EV_RD,
        ST_EV_MUL,
        ST_EV_T,
        ST_SER_MUL,
        ST_SER_REC,
        ST_SER_FIX,
        ST_EXP,
        ST_WMUL,
        ST_WACC,
        ST_EMIT
    } back_state_t;

    // floor(2^36 / k); the quotient estimate is at most one low
    function automatic logic [36:0] recip_q36(input logic [3:0] k);
        logic [36:0] r;
        unique case (k)
            4'd1:    r = 37'd68719476736;
            4'd2:    r = 37'd34359738368;
            4'd3:    r = 37'd22906492245;
            4'd4:    r = 37'd17179869184;
            4'd5:    r = 37'd13743895347;
            4'd6:    r = 37'd11453246122;
            4'd7:    r = 37'd9817068105;
            4'd8:    r = 37'd8589934592;
            4'd9:    r = 37'd7635497415;
            4'd10:   r = 37'd6871947673;
            4'd11:   r = 37'd6247225157;
            4'd12:   r = 37'd5726623061;
            4'd13:   r = 37'd5286113595;
            4'd14:   r = 37'd4908534052;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/grbf_if.sv
`default_nettype none
interface grbf_in_if import grbf_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic [BIDX_W-1:0]         basis_index;
    logic [DIDX_W-1:0]         dim_index;
    logic signed [COORD_W-1:0] coord_value;
    logic [WEIGHT_W-1:0]       weight_value;
    logic                      last_coord;

    modport source (
        output valid, func, basis_index, dim_index, coord_value, weight_value, last_coord,
        input  ready
    );
    modport sink (
        input  valid, func, basis_index, dim_index, coord_value, weight_value, last_coord,
        output ready
    );
endinterface

interface grbf_out_if import grbf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [RATIO_W-1:0] ratio;
    logic               saturated;

    modport source (
        output valid, ratio, saturated,
        input  ready
    );
    modport sink (
        input  valid, ratio, saturated,
        output ready
    );
endinterface
`default_nettype wire

FILE: design/grbf_front.sv
`default_nettype none
module grbf_front import grbf_pkg::*; #(
    parameter int NUM_BASIS = NUM_BASIS_DEF,
    parameter int DIMS      = DIMS_DEF
) (
    grbf_in_if.sink smp_in,
    input  logic    clearing,
    input  logic    push_ready,
    output logic    push_valid,
    output cmd_t    push_cmd
);

    logic keep;
    logic bidx_ok;
    logic didx_ok;

    assign bidx_ok = int'(smp_in.basis_index) < NUM_BASIS;
    assign didx_ok = int'(smp_in.dim_index) < DIMS;
    assign smp_in.ready = push_ready && !clearing;

    always_comb
    begin
        keep            = 1'b0;
        push_cmd.op     = OP_SAMPLE;
        push_cmd.bidx   = smp_in.basis_index;
        push_cmd.didx   = smp_in.dim_index;
        push_cmd.coord  = smp_in.coord_value;
        push_cmd.weight = smp_in.weight_value;
        push_cmd.acc_en = didx_ok;
        push_cmd.last   = smp_in.last_coord;
        unique case (func_t'(smp_in.func))
            FUNC_CENTER:
            begin
                push_cmd.op = OP_CENTER;
                keep        = bidx_ok && didx_ok;
            end
            FUNC_WEIGHT:
            begin
                push_cmd.op = OP_WEIGHT;
                keep        = bidx_ok;
            end
            FUNC_SAMPLE:
            begin
                push_cmd.op = OP_SAMPLE;
                keep        = 1'b1;
            end
            FUNC_NONE:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // dropped transactions are still accepted, they just never reach the queue
    assign push_valid = smp_in.valid && smp_in.ready && keep;

endmodule
`default_nettype wire

FILE: design/grbf_queue.sv
`default_nettype none
module grbf_queue import grbf_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  cmd_t push_cmd,
    output logic push_ready,
    output logic pop_valid,
    output cmd_t pop_cmd,
    input  logic pop
);

    cmd_t       slot_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg;
    logic       rp_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = cnt_reg != 2'd2;
    assign pop_valid  = cnt_reg != 2'd0;
    assign pop_cmd    = slot_reg[rp_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (do_push)
                wp_reg <= !wp_reg;
            if (do_pop)
                rp_reg <= !rp_reg;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wp_reg] <= push_cmd;
    end

endmodule
`default_nettype wire

FILE: design/grbf_back.sv
`default_nettype none
module grbf_back import grbf_pkg::*; #(
    parameter int NUM_BASIS = NUM_BASIS_DEF,
    parameter int DIMS      = DIMS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  cmd_t             q_cmd,
    output logic             q_pop,
    input  logic [INV_W-1:0] inv_two_sigma_sq,
    output logic             clearing,
    grbf_out_if.source       res_out
);

    localparam int BW     = (NUM_BASIS > 1) ? $clog2(NUM_BASIS) : 1;
    localparam int CDEPTH = NUM_BASIS * DIMS;
    localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam logic [BW:0] LAST_IDX = (BW+1)'(NUM_BASIS - 1);
    localparam logic [BW:0] NB_CNT   = (BW+1)'(NUM_BASIS);

    logic signed [COORD_W-1:0] center_mem [CDEPTH];
    logic [WEIGHT_W-1:0]       weight_mem [NUM_BASIS];
    logic [DIST_W-1:0]         dist_mem   [NUM_BASIS];

    back_state_t state_reg, state_next;

    logic [BW:0]   idx_reg;
    logic          v1_reg, v2_reg;
    logic          dsat_reg;
    logic          ssat_reg;
    logic [31:0]   sum_reg;
    logic          out_v_reg;

    logic signed [COORD_W-1:0] cq_reg;
    logic [WEIGHT_W-1:0]       wq_reg;
    logic [DIST_W-1:0]         dq_reg;
    logic signed [COORD_W-1:0] x_reg;
    logic [DIDX_W-1:0]         didx_reg;
    logic                      last_reg;
    logic [BW-1:0]             idx1_reg, idx2_reg;
    logic [DIST_W-1:0]         d2_reg;
    logic [DIST_W-1:0]         sq_reg;
    logic [47:0]               phi_reg, plo_reg;
    logic [WEIGHT_W-1:0]       w_reg;
    logic [31:0]               f_reg;
    logic [4:0]                n_reg;
    logic [4:0]                cnt_reg;
    logic [32:0]               term_reg;
    logic signed [34:0]        ssum_reg;
    logic [3:0]                k_reg;
    logic [31:0]               xs_reg;
    logic [31:0]               q0_reg;
    logic [32:0]               e_reg;
    logic [64:0]               wp_reg;
    logic [RATIO_W-1:0]        ratio_reg;
    logic                      rsat_reg;

    logic           c_we, w_we, d_we, issue, emit;
    logic [CAW-1:0] c_waddr, c_raddr;
    logic [BW-1:0]  d_waddr, d_raddr;
    logic [DIST_W-1:0] d_wdata;

    // accumulate datapath
    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]        mag;
    logic [DIST_W:0]         acc_sum;
    logic [DIST_W-1:0]       acc_sat;

    // kernel datapath
    logic [56:0]         t_val;
    logic [64:0]         ser_prod;
    logic [68:0]         rec_prod;
    logic [35:0]         qk;
    logic [31:0]         rem;
    logic [31:0]         qfix;
    logic signed [34:0]  ssum_new;
    logic [63:0]         exp_prod;
    logic [65:0]         rnd_sum;
    logic [33:0]         tot;

    assign diff    = {x_reg[COORD_W-1], x_reg} - {cq_reg[COORD_W-1], cq_reg};
    assign mag     = diff[COORD_W] ? 25'(-diff) : 25'(diff);
    assign acc_sum = {1'b0, d2_reg} + {1'b0, sq_reg};
    assign acc_sat = acc_sum[DIST_W] ? '1 : acc_sum[DIST_W-1:0];

    assign t_val    = {1'b0, phi_reg, 8'd0} + 57'(plo_reg[47:16]);
    assign ser_prod = term_reg * f_reg;
    assign rec_prod = xs_reg * recip_q36(k_reg);
    assign qk       = q0_reg * k_reg;
    assign rem      = xs_reg - qk[31:0];
    assign qfix     = (rem >= {28'd0, k_reg}) ? q0_reg + 32'd1 : q0_reg;
    assign ssum_new = k_reg[0] ? ssum_reg - $signed({3'd0, qfix})
                               : ssum_reg + $signed({3'd0, qfix});
    assign exp_prod = e_reg * EXP_NEG1_Q32;
    assign rnd_sum  = {1'b0, wp_reg} + 66'h80000000;
    assign tot      = {2'd0, sum_reg} + rnd_sum[65:32];

    assign c_waddr = CAW'(int'(q_cmd.bidx) * DIMS + int'(q_cmd.didx));
    assign c_raddr = CAW'(int'(idx_reg[BW-1:0]) * DIMS + int'(didx_reg));
    assign d_raddr = idx_reg[BW-1:0];

    assign clearing        = state_reg == ST_CLEAR;
    assign res_out.valid     = out_v_reg;
    assign res_out.ratio     = ratio_reg;
    assign res_out.saturated = rsat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        c_we       = 1'b0;
        w_we       = 1'b0;
        d_we       = 1'b0;
        d_waddr    = idx_reg[BW-1:0];
        d_wdata    = '0;
        issue      = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                d_we = 1'b1;
                if (idx_reg == LAST_IDX)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_cmd.op)
                        OP_CENTER: c_we = 1'b1;
                        OP_WEIGHT: w_we = 1'b1;
                        OP_SAMPLE:
                        begin
                            if (q_cmd.acc_en)
                                state_next = ST_ACC;
                            else if (q_cmd.last)
                                state_next = ST_EV_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ACC:
            begin
                issue = idx_reg != NB_CNT;
                if (v2_reg)
                begin
                    d_we    = 1'b1;
                    d_waddr = idx2_reg;
                    d_wdata = acc_sat;
                end
                if (!issue && !v1_reg && !v2_reg)
                    state_next = last_reg ? ST_EV_RD : ST_IDLE;
            end
            ST_EV_RD:   state_next = ST_EV_MUL;
            ST_EV_MUL:  state_next = ST_EV_T;
            ST_EV_T:    state_next = (|t_val[56:37]) ? ST_WMUL : ST_SER_MUL;
            ST_SER_MUL: state_next = ST_SER_REC;
            ST_SER_REC: state_next = ST_SER_FIX;
            ST_SER_FIX:
                state_next = (k_reg == 4'(SERIES_TERMS)) ? ST_EXP : ST_SER_MUL;
            ST_EXP:
            begin
                if (cnt_reg == n_reg)
                    state_next = ST_WMUL;
            end
            ST_WMUL:    state_next = ST_WACC;
            ST_WACC:
            begin
                d_we       = 1'b1;
                state_next = (idx_reg == LAST_IDX) ? ST_EMIT : ST_EV_RD;
            end
            ST_EMIT:
            begin
                if (!out_v_reg || res_out.ready)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            dsat_reg  <= 1'b0;
            ssat_reg  <= 1'b0;
            sum_reg   <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            unique case (state_reg)
                ST_CLEAR: idx_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
                ST_IDLE:  idx_reg <= '0;
                ST_ACC:
                begin
                    if (issue)
                        idx_reg <= idx_reg + 1'b1;
                    else if (!v1_reg && !v2_reg)
                        idx_reg <= '0;
                end
                ST_WACC:
                begin
                    if (idx_reg != LAST_IDX)
                        idx_reg <= idx_reg + 1'b1;
                end
                default: ;
            endcase
            if (v2_reg && acc_sum[DIST_W])
                dsat_reg <= 1'b1;
            if (state_reg == ST_WACC)
            begin
                sum_reg <= (|tot[33:32]) ? '1 : tot[31:0];
                if (|tot[33:32])
                    ssat_reg <= 1'b1;
            end
            if (emit)
            begin
                out_v_reg <= 1'b1;
                dsat_reg  <= 1'b0;
                ssat_reg  <= 1'b0;
                sum_reg   <= '0;
            end
            else if (res_out.ready)
                out_v_reg <= 1'b0;
        end
    end

    // memories: one write and registered reads per cycle
    always_ff @(posedge clk)
    begin
        if (c_we)
            center_mem[c_waddr] <= q_cmd.coord;
        cq_reg <= center_mem[c_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
            weight_mem[BW'(q_cmd.bidx)] <= q_cmd.weight;
        wq_reg <= weight_mem[d_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
            dist_mem[d_waddr] <= d_wdata;
        dq_reg <= dist_mem[d_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_cmd.op == OP_SAMPLE)
        begin
            x_reg    <= q_cmd.coord;
            didx_reg <= q_cmd.didx;
            last_reg <= q_cmd.last;
        end
        idx1_reg <= idx_reg[BW-1:0];
        idx2_reg <= idx1_reg;
        d2_reg   <= dq_reg;
        sq_reg   <= mag[COORD_W-1:0] * mag[COORD_W-1:0];
        if (emit)
        begin
            ratio_reg <= sum_reg;
            rsat_reg  <= ssat_reg || dsat_reg;
        end
        unique case (state_reg)
            ST_EV_MUL:
            begin
                phi_reg <= dq_reg[47:24] * inv_two_sigma_sq;
                plo_reg <= dq_reg[23:0] * inv_two_sigma_sq;
                w_reg   <= wq_reg;
            end
            ST_EV_T:
            begin
                f_reg    <= t_val[31:0];
                n_reg    <= t_val[36:32];
                term_reg <= 33'h100000000;
                ssum_reg <= 35'sh100000000;
                k_reg    <= 4'd1;
                e_reg    <= '0;
            end
            ST_SER_MUL: xs_reg <= ser_prod[63:32];
            ST_SER_REC: q0_reg <= rec_prod[67:36];
            ST_SER_FIX:
            begin
                term_reg <= {1'b0, qfix};
                ssum_reg <= ssum_new;
                k_reg    <= k_reg + 4'd1;
                e_reg    <= ssum_new[32:0];
                cnt_reg  <= '0;
            end
            ST_EXP:
            begin
                if (cnt_reg != n_reg)
                begin
                    e_reg   <= {1'b0, exp_prod[63:32]};
                    cnt_reg <= cnt_reg + 5'd1;
                end
            end
            ST_WMUL: wp_reg <= w_reg * e_reg;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

FILE: design/gaussian_rbf_ratio_eval_unit.sv
`default_nettype none
// Channel   | Dir | Handshake     | Payload
// smp_in    | in  | valid/ready   | func, basis_index, dim_index, coord_value,
//           |     |               | weight_value, last_coord
// res_out   | out | valid/ready   | ratio, saturated
// apb       | in  | psel/penable  | inv_two_sigma_sq at byte address 0
//
// Center and weight loads retire straight from the idle state.
// A sample coordinate sweeps every basis entry, one per cycle, after the queue
// pop, then drains the read, square and write-back pipeline.
// The last coordinate then runs the exp unit per basis entry: 14 series terms
// for exp(-f) through the multiply-and-correct divider loop, then n multiplies
// by exp(-1) (n < 32); when n >= 32 the series is skipped and the term is zero.
// After reset a clearing pass zeroes every entry of the distance memory;
// input is held off meanwhile. A two-entry queue decouples input from execution,
// and the result register lets the next transaction in while a result waits.
module gaussian_rbf_ratio_eval_unit import grbf_pkg::*; #(
    parameter int NUM_BASIS = NUM_BASIS_DEF,
    parameter int DIMS      = DIMS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    grbf_in_if.sink           smp_in,
    grbf_out_if.source        res_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [INV_W-1:0] inv_reg;
    logic             clearing;
    logic             push_valid, push_ready;
    cmd_t             push_cmd;
    logic             pop_valid, pop;
    cmd_t             pop_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_INV_ADDR) ? APB_DW'(inv_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inv_reg <= INV_RESET;
        else if (psel && penable && pwrite && pready && paddr == REG_INV_ADDR)
            inv_reg <= pwdata[INV_W-1:0];
    end

    grbf_front #(
        .NUM_BASIS (NUM_BASIS),
        .DIMS      (DIMS)
    ) u_front (
        .smp_in     (smp_in),
        .clearing   (clearing),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    grbf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop        (pop)
    );

    grbf_back #(
        .NUM_BASIS (NUM_BASIS),
        .DIMS      (DIMS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (pop_valid),
        .q_cmd            (pop_cmd),
        .q_pop            (pop),
        .inv_two_sigma_sq (inv_reg),
        .clearing         (clearing),
        .res_out          (res_out)
    );

    a_no_input_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clearing |-> !smp_in.ready
    ) else $error("input taken during clearing pass");

    a_no_queue_overflow: assert property (
        @(posedge clk) disable iff (!rst_n) push_valid |-> push_ready
    ) else $error("queue push while full");

    a_pop_only_valid: assert property (
        @(posedge clk) disable iff (!rst_n) pop |-> pop_valid
    ) else $error("queue pop while empty");

endmodule
`default_nettype wire
